// ===== sv/nfci_pkg.sv =====
// Shared types and constants for the NOR flash command interpreter.
`timescale 1ns / 1ps

package nfci_pkg;

    localparam int ADDR_W           = 12;
    localparam int DATA_W           = 16;
    localparam int ARRAY_WORDS_DEF  = 4096;
    localparam int SECTOR_WORDS_DEF = 1024;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [10:0]       UNLOCK_ADDR1 = 11'h555;
    localparam logic [10:0]       UNLOCK_ADDR2 = 11'h2AA;
    localparam logic [DATA_W-1:0] CMD_UNLOCK1      = 16'h00AA;
    localparam logic [DATA_W-1:0] CMD_UNLOCK2      = 16'h0055;
    localparam logic [DATA_W-1:0] CMD_ERASE_SETUP  = 16'h0080;
    localparam logic [DATA_W-1:0] CMD_SECTOR_ERASE = 16'h0030;
    localparam logic [DATA_W-1:0] CMD_PROGRAM      = 16'h00A0;
    localparam logic [DATA_W-1:0] CMD_RESET        = 16'h00F0;
    localparam logic [DATA_W-1:0] ERASED_WORD      = 16'hFFFF;

    localparam logic BUS_READ  = 1'b0;
    localparam logic BUS_WRITE = 1'b1;

    localparam logic [1:0] DONE_NONE    = 2'd0;
    localparam logic [1:0] DONE_PROGRAM = 2'd1;
    localparam logic [1:0] DONE_ERASE   = 2'd2;
    localparam logic [1:0] DONE_RESET   = 2'd3;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } request_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [1:0]        op_done;
        logic              sequence_error;
    } result_t;

    typedef enum logic [2:0] {
        PH_READ           = 3'd0,
        PH_UNLOCK1        = 3'd1,
        PH_UNLOCKED       = 3'd2,
        PH_PROGRAM        = 3'd3,
        PH_ERASE_SETUP    = 3'd4,
        PH_ERASE_UNLOCK1  = 3'd5,
        PH_ERASE_UNLOCKED = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_PROGRAM = 2'd1,
        OP_ERASE   = 2'd2,
        OP_STATUS  = 2'd3
    } op_kind_t;

    // Classified request handed from front to back.
    typedef struct packed {
        op_kind_t          kind;
        logic [ADDR_W-1:0] idx;
        logic [DATA_W-1:0] data;
        logic [1:0]        done;
        logic              err;
    } op_t;

    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_READ,
        BK_PROG,
        BK_DIV,
        BK_ERASE
    } back_state_t;

endpackage

// ===== sv/nor_flash_command_interpreter_core.sv =====
// Top level of the NOR flash command interpreter.
`timescale 1ns / 1ps

// A request (read or write at a word offset) is taken on a clock edge with
// start high and busy low; each request yields exactly one result, shown for
// one cycle with result_valid high, in request order, and the receiver cannot
// stall it. The front decodes the command phase in the cycle of the request and
// queues an operation (two entries); busy rises only while that queue is full
// or while the array is being cleared. After reset the back end writes 0xFFFF
// to every word, one word a cycle, and busy stays high until the clear is done.
// In the back end a read or a word program passes through a registered array
// read, then the result or the write back; any other write (reset, command
// step or broken sequence) gives its result straight from idle; and a sector
// erase finds the sector base from a reciprocal multiply and a multiply by the
// sector size, then writes one word per cycle up to the sector or array end.

module nor_flash_command_interpreter_core #(
    parameter int ARRAY_WORDS  = nfci_pkg::ARRAY_WORDS_DEF,
    parameter int SECTOR_WORDS = nfci_pkg::SECTOR_WORDS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  nfci_pkg::request_t request,
    output logic               busy,
    output logic               result_valid,
    output nfci_pkg::result_t  result
);

    logic          push, pop, empty, full, init_active;
    nfci_pkg::op_t push_op, head_op;

    nfci_front #(
        .ARRAY_WORDS(ARRAY_WORDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .request    (request),
        .queue_full (full),
        .init_active(init_active),
        .busy       (busy),
        .push       (push),
        .push_op    (push_op)
    );

    nfci_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .push_op(push_op),
        .pop    (pop),
        .head_op(head_op),
        .empty  (empty),
        .full   (full)
    );

    nfci_back #(
        .ARRAY_WORDS (ARRAY_WORDS),
        .SECTOR_WORDS(SECTOR_WORDS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_op     (head_op),
        .empty       (empty),
        .pop         (pop),
        .init_active (init_active),
        .result_valid(result_valid),
        .result      (result)
    );

endmodule

// ===== sv/nfci_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module nfci_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/nfci_queue.sv =====
// Small FIFO of classified operations between front and back.
`timescale 1ns / 1ps

module nfci_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  nfci_pkg::op_t push_op,
    input  logic          pop,
    output nfci_pkg::op_t head_op,
    output logic          empty,
    output logic          full
);

    localparam int PW = $clog2(nfci_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(nfci_pkg::QUEUE_DEPTH + 1);

    nfci_pkg::op_t entry_reg [nfci_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(nfci_pkg::QUEUE_DEPTH));
    assign head_op = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(nfci_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(nfci_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ===== sv/nfci_front.sv =====
// Front end: accepts bus requests, tracks the command phase, classifies ops.
`timescale 1ns / 1ps

module nfci_front #(
    parameter int ARRAY_WORDS = nfci_pkg::ARRAY_WORDS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  nfci_pkg::request_t request,
    input  logic               queue_full,
    input  logic               init_active,
    output logic               busy,
    output logic               push,
    output nfci_pkg::op_t      push_op
);

    // Address is below 4096; the user must give an array of at least 2048 words,
    // which the block does not check, so one conditional subtract wraps it.
    localparam logic [nfci_pkg::ADDR_W:0] WRAP =
        (ARRAY_WORDS >= 4096) ? 13'h1000 : (nfci_pkg::ADDR_W + 1)'(ARRAY_WORDS);

    nfci_pkg::phase_t phase_reg, phase_next;
    logic [nfci_pkg::ADDR_W:0]   addr_ext;
    logic [nfci_pkg::ADDR_W-1:0] idx;
    logic [10:0]                 dec;
    logic                        at1, at2, ok;
    logic [nfci_pkg::DATA_W-1:0] data;

    assign busy     = queue_full || init_active;
    assign push     = start && !busy;
    assign addr_ext = {1'b0, request.address};
    assign idx      = (addr_ext >= WRAP) ? nfci_pkg::ADDR_W'(addr_ext - WRAP)
                                         : request.address;
    assign dec      = request.address[10:0];
    assign at1      = (dec == nfci_pkg::UNLOCK_ADDR1);
    assign at2      = (dec == nfci_pkg::UNLOCK_ADDR2);
    assign data     = request.write_data;

    always_comb
    begin
        phase_next   = phase_reg;
        ok           = 1'b0;
        push_op.kind = nfci_pkg::OP_STATUS;
        push_op.idx  = idx;
        push_op.data = data;
        push_op.done = nfci_pkg::DONE_NONE;
        push_op.err  = 1'b0;
        if (request.command == nfci_pkg::BUS_READ)
        begin
            push_op.kind = nfci_pkg::OP_READ;
        end
        else if (phase_reg == nfci_pkg::PH_PROGRAM)
        begin
            push_op.kind = nfci_pkg::OP_PROGRAM;
            phase_next   = nfci_pkg::PH_READ;
        end
        else if (data == nfci_pkg::CMD_RESET)
        begin
            push_op.done = nfci_pkg::DONE_RESET;
            phase_next   = nfci_pkg::PH_READ;
        end
        else
        begin
            phase_next = nfci_pkg::PH_READ;
            case (phase_reg)
                nfci_pkg::PH_UNLOCK1:
                begin
                    if (at2 && data == nfci_pkg::CMD_UNLOCK2)
                    begin
                        phase_next = nfci_pkg::PH_UNLOCKED;
                        ok         = 1'b1;
                    end
                end
                nfci_pkg::PH_UNLOCKED:
                begin
                    if (at1 && data == nfci_pkg::CMD_PROGRAM)
                    begin
                        phase_next = nfci_pkg::PH_PROGRAM;
                        ok         = 1'b1;
                    end
                    else if (at1 && data == nfci_pkg::CMD_ERASE_SETUP)
                    begin
                        phase_next = nfci_pkg::PH_ERASE_SETUP;
                        ok         = 1'b1;
                    end
                end
                nfci_pkg::PH_ERASE_SETUP:
                begin
                    if (at1 && data == nfci_pkg::CMD_UNLOCK1)
                    begin
                        phase_next = nfci_pkg::PH_ERASE_UNLOCK1;
                        ok         = 1'b1;
                    end
                end
                nfci_pkg::PH_ERASE_UNLOCK1:
                begin
                    if (at2 && data == nfci_pkg::CMD_UNLOCK2)
                    begin
                        phase_next = nfci_pkg::PH_ERASE_UNLOCKED;
                        ok         = 1'b1;
                    end
                end
                nfci_pkg::PH_ERASE_UNLOCKED:
                begin
                    if (data == nfci_pkg::CMD_SECTOR_ERASE)
                    begin
                        push_op.kind = nfci_pkg::OP_ERASE;
                        ok           = 1'b1;
                    end
                end
                default:
                begin
                    if (at1 && data == nfci_pkg::CMD_UNLOCK1)
                    begin
                        phase_next = nfci_pkg::PH_UNLOCK1;
                        ok         = 1'b1;
                    end
                end
            endcase
            push_op.err = !ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= nfci_pkg::PH_READ;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== sv/nfci_back.sv =====
// Back end: array clear after reset, reads, word program, sector erase, status results.
`timescale 1ns / 1ps

module nfci_back #(
    parameter int ARRAY_WORDS  = nfci_pkg::ARRAY_WORDS_DEF,
    parameter int SECTOR_WORDS = nfci_pkg::SECTOR_WORDS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  nfci_pkg::op_t     head_op,
    input  logic              empty,
    output logic              pop,
    output logic              init_active,
    output logic              result_valid,
    output nfci_pkg::result_t result
);

    localparam int AW = $clog2(ARRAY_WORDS);
    localparam int CW = (SECTOR_WORDS > 1) ? $clog2(SECTOR_WORDS) : 1;
    localparam int IW = nfci_pkg::ADDR_W;

    // Reciprocal of the sector size, exact for every IW-bit index.
    localparam int              QS      = IW + $clog2(SECTOR_WORDS);
    localparam int              MW      = IW + 1;
    localparam longint unsigned QM_FULL =
        ((64'd1 << QS) + 64'(SECTOR_WORDS) - 64'd1) / 64'(SECTOR_WORDS);
    localparam logic [MW-1:0]   QM       = MW'(QM_FULL);
    localparam int              SW       = $clog2(SECTOR_WORDS + 1);
    localparam logic [SW-1:0]   SECTOR_K = SW'(SECTOR_WORDS);

    nfci_pkg::back_state_t state_reg, state_next;
    logic [AW-1:0]                 addr_reg, addr_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [IW-1:0]                 quot_reg, quot_next;
    logic [IW-1:0]                 idx_reg, idx_next;
    logic [nfci_pkg::DATA_W-1:0]   data_reg, data_next;
    logic                          result_valid_reg, result_valid_next;
    nfci_pkg::result_t             result_reg, result_next;

    logic                          we;
    logic [AW-1:0]                 waddr, raddr;
    logic [nfci_pkg::DATA_W-1:0]   wdata, rdata;
    logic [IW+MW-1:0]              qprod;
    logic [IW-1:0]                 quot;
    logic [IW+SW-1:0]              bprod;
    logic [IW-1:0]                 base;
    logic                          last;

    nfci_ram #(
        .WIDTH(nfci_pkg::DATA_W),
        .DEPTH(ARRAY_WORDS)
    ) u_array (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign init_active  = (state_reg == nfci_pkg::BK_INIT);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Sector base: quotient by reciprocal multiply at pop, times sector size next cycle.
    assign qprod = (IW + MW)'(head_op.idx) * (IW + MW)'(QM);
    assign quot  = IW'(qprod >> QS);
    assign bprod = (IW + SW)'(quot_reg) * (IW + SW)'(SECTOR_K);
    assign base  = IW'(bprod);
    assign last  = (cnt_reg == CW'(SECTOR_WORDS - 1)) || (addr_reg == AW'(ARRAY_WORDS - 1));

    always_comb
    begin
        state_next        = state_reg;
        addr_next         = addr_reg;
        cnt_next          = cnt_reg;
        quot_next         = quot_reg;
        idx_next          = idx_reg;
        data_next         = data_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        pop               = 1'b0;
        we                = 1'b0;
        waddr             = addr_reg;
        wdata             = nfci_pkg::ERASED_WORD;
        raddr             = AW'(head_op.idx);
        case (state_reg)
            nfci_pkg::BK_INIT:
            begin
                we = 1'b1;
                if (addr_reg == AW'(ARRAY_WORDS - 1))
                begin
                    state_next = nfci_pkg::BK_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            nfci_pkg::BK_IDLE:
            begin
                if (!empty)
                begin
                    pop       = 1'b1;
                    idx_next  = head_op.idx;
                    data_next = head_op.data;
                    case (head_op.kind)
                        nfci_pkg::OP_READ:    state_next = nfci_pkg::BK_READ;
                        nfci_pkg::OP_PROGRAM: state_next = nfci_pkg::BK_PROG;
                        nfci_pkg::OP_ERASE:
                        begin
                            quot_next  = quot;
                            state_next = nfci_pkg::BK_DIV;
                        end
                        default:
                        begin
                            result_valid_next          = 1'b1;
                            result_next.read_data      = '0;
                            result_next.op_done        = head_op.done;
                            result_next.sequence_error = head_op.err;
                        end
                    endcase
                end
            end
            nfci_pkg::BK_READ:
            begin
                result_valid_next          = 1'b1;
                result_next.read_data      = rdata;
                result_next.op_done        = nfci_pkg::DONE_NONE;
                result_next.sequence_error = 1'b0;
                state_next                 = nfci_pkg::BK_IDLE;
            end
            nfci_pkg::BK_PROG:
            begin
                we                         = 1'b1;
                waddr                      = AW'(idx_reg);
                wdata                      = rdata & data_reg;
                result_valid_next          = 1'b1;
                result_next.read_data      = '0;
                result_next.op_done        = nfci_pkg::DONE_PROGRAM;
                result_next.sequence_error = 1'b0;
                state_next                 = nfci_pkg::BK_IDLE;
            end
            nfci_pkg::BK_DIV:
            begin
                addr_next  = AW'(base);
                cnt_next   = '0;
                state_next = nfci_pkg::BK_ERASE;
            end
            nfci_pkg::BK_ERASE:
            begin
                we = 1'b1;
                if (last)
                begin
                    result_valid_next          = 1'b1;
                    result_next.read_data      = '0;
                    result_next.op_done        = nfci_pkg::DONE_ERASE;
                    result_next.sequence_error = 1'b0;
                    state_next                 = nfci_pkg::BK_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = nfci_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= nfci_pkg::BK_INIT;
            addr_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            addr_reg         <= addr_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        quot_reg   <= quot_next;
        idx_reg    <= idx_next;
        data_reg   <= data_next;
        result_reg <= result_next;
    end

endmodule
